[rtl/core/sida_pkg.sv]
package sida_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;

   // Decimal digits needed for 2**(bits-1); 77/256 stands in for log10(2),
   // close enough for every width up to 64.
   function automatic int num_digits(input int bits);
      return ((bits - 1) * 77) / 256 + 1;
   endfunction

   typedef enum logic [1:0] {
      SEL_MINUS   = 2'd0,
      SEL_DIGIT   = 2'd1,
      SEL_NEWLINE = 2'd2
   } char_sel_type;

   typedef struct packed {
      logic         load;
      logic         dabble;
      logic         shift_digit;
      char_sel_type char_sel;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic top_zero;
      logic cnt_zero;
   } status_type;

endpackage

[rtl/core/sida_if.sv]
interface sida_req_if #(
   parameter int WIDTH = sida_pkg::VALUE_BITS_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sida_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_char;

   modport source (output valid, output char_byte, output last_char, input ready);
   modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

[rtl/core/sida_datapath.sv]
module sida_datapath #(
   parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic signed [VALUE_BITS-1:0] value,
   input  sida_pkg::cmd_type            cmd,
   output sida_pkg::status_type         status,
   output logic [7:0]                   char_byte,
   output logic                         last_char
);
   import sida_pkg::*;

   localparam int NUM_DIGITS = num_digits(VALUE_BITS);
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [BCD_W-1:0]      adj;
   logic [3:0]            top_digit;

   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         neg_in = value[VALUE_BITS-1];
         // unsigned negate keeps the most negative value exact
         mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
         bcd_in = '0;
         cnt_in = CNT_W'(VALUE_BITS - 1);
      end else if (cmd.dabble) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = (cnt_ff == '0) ? CNT_W'(NUM_DIGITS - 1) : cnt_ff - 1'b1;
      end else if (cmd.shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign top_digit       = bcd_ff[BCD_W-1 -: 4];
   assign status.neg      = neg_ff;
   assign status.top_zero = (top_digit == 4'd0);
   assign status.cnt_zero = (cnt_ff == '0);

   always_comb begin
      case (cmd.char_sel)
         SEL_MINUS:   char_byte = CH_MINUS;
         SEL_DIGIT:   char_byte = CH_ZERO + {4'd0, top_digit};
         SEL_NEWLINE: char_byte = CH_NEWLINE;
         default:     char_byte = CH_NEWLINE;
      endcase
   end

   assign last_char = (cmd.char_sel == SEL_NEWLINE);

endmodule

[rtl/core/sida_control.sv]
module sida_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sida_pkg::status_type status,
   output sida_pkg::cmd_type    cmd
);
   import sida_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CONVERT = 6'b000010,
      ST_SKIP    = 6'b000100,
      ST_SIGN    = 6'b001000,
      ST_DIGIT   = 6'b010000,
      ST_NEWLINE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in         = state_ff;
      cmd.load         = 1'b0;
      cmd.dabble       = 1'b0;
      cmd.shift_digit  = 1'b0;
      cmd.char_sel     = SEL_DIGIT;
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, always keeping the last digit
            if (status.top_zero && !status.cnt_zero) begin
               cmd.shift_digit = 1'b1;
            end else begin
               state_in = status.neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.char_sel = SEL_MINUS;
            if (rsp_ready) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift_digit = 1'b1;
               if (status.cnt_zero) begin
                  state_in = ST_NEWLINE;
               end
            end
         end
         ST_NEWLINE: begin
            rsp_valid    = 1'b1;
            cmd.char_sel = SEL_NEWLINE;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Converts one signed two's complement integer per item into its decimal text, sent one
// byte per item on the response channel: '-' for a negative value, the digits most
// significant first without leading zeros, then a newline flagged by last_char. The
// most negative value prints its true digits. One number is handled at a time: the
// request is taken, a shift-and-add-3 step for each value bit builds the BCD digits,
// each leading zero is dropped in turn before the zero scan is left, then each output
// byte goes out when the response side is ready. The next request is taken after
// the newline.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sida_req_if.sink   req_chan,
   sida_rsp_if.source rsp_chan
);
   import sida_pkg::*;

   cmd_type    cmd;
   status_type status;

   sida_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sida_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .value     (req_chan.value),
      .cmd       (cmd),
      .status    (status),
      .char_byte (rsp_chan.char_byte),
      .last_char (rsp_chan.last_char)
   );

endmodule

[rtl/core/sida_checker.sv]
module sida_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] char_byte,
   input logic       last_char
);

   // a waiting response byte holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(char_byte) && $stable(last_char))
      else $error("response item changed while stalled");

   // conversion takes cycles, so no byte follows straight after a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response straight after request");

   // the newline frees the block for the next number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_char |=> req_ready && !rsp_valid)
      else $error("block not idle after newline");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while text still going out");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .char_byte (rsp_chan.char_byte),
   .last_char (rsp_chan.last_char)
);
